// ===== design/amc_pkg.sv =====
// package for the addressing mode classifier
// holds field widths, class and mode codes and the decode function
// no dependencies
package amc_pkg;

    localparam int OP_W   = 4;
    localparam int WORD_W = 32;
    localparam int MODE_W = 6;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MODE_W-1:0] mode_t;

    // instruction classes
    localparam op_t OP_DP         = 4'd0;
    localparam op_t OP_LS         = 4'd1;
    localparam op_t OP_LSM        = 4'd2;
    localparam op_t OP_LSMISC     = 4'd3;
    localparam op_t OP_COPROC     = 4'd4;
    localparam op_t OP_VFP_S      = 4'd5;
    localparam op_t OP_VFP_SM     = 4'd6;
    localparam op_t OP_VFP_D      = 4'd7;
    localparam op_t OP_VFP_DM     = 4'd8;
    localparam op_t OP_VFP_LSM    = 4'd9;

    // mode codes
    localparam mode_t MODE_UNKNOWN          = 6'd0;
    localparam mode_t MODE_DATA_IMM         = 6'd1;
    localparam mode_t MODE_DATA_RRX         = 6'd2;
    localparam mode_t MODE_DATA_REG         = 6'd3;
    localparam mode_t MODE_DATA_IMM_LSL     = 6'd4;
    localparam mode_t MODE_DATA_REG_LSL     = 6'd8;
    localparam mode_t MODE_LS_IMM           = 6'd12;
    localparam mode_t MODE_LS_IMM_PRE       = 6'd13;
    localparam mode_t MODE_LS_IMM_POST      = 6'd14;
    localparam mode_t MODE_LS_REG           = 6'd15;
    localparam mode_t MODE_LS_REG_PRE       = 6'd16;
    localparam mode_t MODE_LS_REG_POST      = 6'd17;
    localparam mode_t MODE_LS_SCALED_LSL    = 6'd18;
    localparam mode_t MODE_LS_SCALED_PRE    = 6'd23;
    localparam mode_t MODE_LS_SCALED_POST   = 6'd28;
    localparam mode_t MODE_MISC_IMM         = 6'd33;
    localparam mode_t MODE_MISC_IMM_PRE     = 6'd34;
    localparam mode_t MODE_MISC_IMM_POST    = 6'd35;
    localparam mode_t MODE_MISC_REG         = 6'd36;
    localparam mode_t MODE_MISC_REG_PRE     = 6'd37;
    localparam mode_t MODE_MISC_REG_POST    = 6'd38;
    localparam mode_t MODE_LSM_IA           = 6'd39;
    localparam mode_t MODE_LSM_IB           = 6'd40;
    localparam mode_t MODE_LSM_DA           = 6'd41;
    localparam mode_t MODE_LSM_DB           = 6'd42;
    localparam mode_t MODE_CP_IMM           = 6'd43;
    localparam mode_t MODE_CP_IMM_PRE       = 6'd44;
    localparam mode_t MODE_CP_IMM_POST      = 6'd45;
    localparam mode_t MODE_CP_UNINDEXED     = 6'd46;
    localparam mode_t MODE_VFP_S_SCALAR     = 6'd47;
    localparam mode_t MODE_VFP_SM_SCALAR    = 6'd50;
    localparam mode_t MODE_VFP_D_SCALAR     = 6'd53;
    localparam mode_t MODE_VFP_DM_SCALAR    = 6'd56;
    localparam mode_t MODE_VLSM_UNINDEXED   = 6'd59;
    localparam mode_t MODE_VLSM_INC         = 6'd60;
    localparam mode_t MODE_VLSM_DEC         = 6'd61;

    // shift type and index kind codes
    localparam logic [1:0] SH_ROR       = 2'b11;
    localparam logic [2:0] LS_K_IMM     = 3'b010;
    localparam logic [2:0] LS_K_IMM_PRE = 3'b011;
    localparam logic [2:0] LS_K_IMM_PST = 3'b000;
    localparam logic [2:0] LS_K_REG     = 3'b110;
    localparam logic [2:0] LS_K_REG_PRE = 3'b111;
    localparam logic [2:0] LS_K_REG_PST = 3'b100;
    localparam logic [2:0] MS_K_IMM     = 3'b110;
    localparam logic [2:0] MS_K_IMM_PRE = 3'b111;
    localparam logic [2:0] MS_K_IMM_PST = 3'b010;
    localparam logic [2:0] MS_K_REG     = 3'b100;
    localparam logic [2:0] MS_K_REG_PRE = 3'b101;
    localparam logic [2:0] MS_K_REG_PST = 3'b000;
    localparam logic [1:0] LSM_K_IA     = 2'b01;
    localparam logic [1:0] LSM_K_IB     = 2'b11;
    localparam logic [1:0] LSM_K_DA     = 2'b00;
    localparam logic [1:0] CP_K_IMM     = 2'b10;
    localparam logic [1:0] CP_K_PRE     = 2'b11;
    localparam logic [1:0] CP_K_POST    = 2'b01;
    localparam logic [4:0] VLSM_INC_TOP = 5'b11001;
    localparam logic [4:0] VLSM_DEC_TOP = 5'b11010;
    localparam logic [7:0] RRX_FIELD    = 8'h06;

    // data processing shifter operand
    function automatic mode_t dec_data(input word_t w);
        mode_t sh;
        sh = {4'd0, w[6:5]};
        if (w[27] || w[26])
            return MODE_UNKNOWN;
        if (w[25])
            return MODE_DATA_IMM;
        if (w[11:4] == RRX_FIELD)
            return MODE_DATA_RRX;
        if (!w[4])
        begin
            if (w[11:5] == 7'd0)
                return MODE_DATA_REG;
            return MODE_DATA_IMM_LSL + sh;
        end
        if (!w[7])
            return MODE_DATA_REG_LSL + sh;
        return MODE_UNKNOWN;
    endfunction

    // load/store word or byte
    function automatic mode_t dec_ls(input word_t w);
        logic [2:0] kind;
        mode_t      reg_mode;
        mode_t      scaled_base;
        mode_t      off;
        kind = {w[25], w[24], w[21]};
        reg_mode = MODE_UNKNOWN;
        scaled_base = MODE_UNKNOWN;
        off = {4'd0, w[6:5]};
        if (w[27] || !w[26])
            return MODE_UNKNOWN;
        unique case (kind)
            LS_K_IMM:     return MODE_LS_IMM;
            LS_K_IMM_PRE: return MODE_LS_IMM_PRE;
            LS_K_IMM_PST: return MODE_LS_IMM_POST;
            LS_K_REG:
            begin
                reg_mode = MODE_LS_REG;
                scaled_base = MODE_LS_SCALED_LSL;
            end
            LS_K_REG_PRE:
            begin
                reg_mode = MODE_LS_REG_PRE;
                scaled_base = MODE_LS_SCALED_PRE;
            end
            LS_K_REG_PST:
            begin
                reg_mode = MODE_LS_REG_POST;
                scaled_base = MODE_LS_SCALED_POST;
            end
            default:      return MODE_UNKNOWN;
        endcase
        if (w[11:4] == 8'd0)
            return reg_mode;
        if (w[4])
            return MODE_UNKNOWN;
        // ror by zero is rrx
        if (w[6:5] == SH_ROR && w[11:7] == 5'd0)
            off = 6'd4;
        return scaled_base + off;
    endfunction

    // miscellaneous load/store
    function automatic mode_t dec_misc(input word_t w);
        logic [2:0] kind;
        kind = {w[24], w[22], w[21]};
        if (w[27] || w[26] || w[25] || !w[7] || !w[4])
            return MODE_UNKNOWN;
        unique case (kind)
            MS_K_IMM:     return MODE_MISC_IMM;
            MS_K_IMM_PRE: return MODE_MISC_IMM_PRE;
            MS_K_IMM_PST: return MODE_MISC_IMM_POST;
            MS_K_REG:     return MODE_MISC_REG;
            MS_K_REG_PRE: return MODE_MISC_REG_PRE;
            MS_K_REG_PST: return MODE_MISC_REG_POST;
            default:      return MODE_UNKNOWN;
        endcase
    endfunction

    // load/store multiple
    function automatic mode_t dec_lsm(input word_t w);
        if (!w[27] || w[26] || w[25])
            return MODE_UNKNOWN;
        unique case (w[24:23])
            LSM_K_IA: return MODE_LSM_IA;
            LSM_K_IB: return MODE_LSM_IB;
            LSM_K_DA: return MODE_LSM_DA;
            default:  return MODE_LSM_DB;
        endcase
    endfunction

    // coprocessor load/store, indexing from p and w
    function automatic mode_t dec_coproc(input word_t w);
        if (!w[27] || !w[26] || w[25])
            return MODE_UNKNOWN;
        unique case ({w[24], w[21]})
            CP_K_IMM:  return MODE_CP_IMM;
            CP_K_PRE:  return MODE_CP_IMM_PRE;
            CP_K_POST: return MODE_CP_IMM_POST;
            default:   return MODE_CP_UNINDEXED;
        endcase
    endfunction

    // vfp register banks: scalar, mixed or vector
    function automatic mode_t dec_vfp_bank(input word_t w, input mode_t first);
        if (w[15:14] == 2'd0)
            return first;
        if (w[3:2] == 2'd0)
            return first + 6'd1;
        return first + 6'd2;
    endfunction

    // vfp load/store multiple
    function automatic mode_t dec_vfp_lsm(input word_t w);
        if (w[27:23] == VLSM_INC_TOP)
            return w[21] ? MODE_VLSM_INC : MODE_VLSM_UNINDEXED;
        if (w[27:23] == VLSM_DEC_TOP && w[21])
            return MODE_VLSM_DEC;
        return MODE_UNKNOWN;
    endfunction

    // class selects the decoder
    function automatic mode_t decode_mode(input op_t op, input word_t w);
        unique case (op)
            OP_DP:      return dec_data(w);
            OP_LS:      return dec_ls(w);
            OP_LSM:     return dec_lsm(w);
            OP_LSMISC:  return dec_misc(w);
            OP_COPROC:  return dec_coproc(w);
            OP_VFP_S:   return dec_vfp_bank(w, MODE_VFP_S_SCALAR);
            OP_VFP_SM:  return dec_vfp_bank(w, MODE_VFP_SM_SCALAR);
            OP_VFP_D:   return dec_vfp_bank(w, MODE_VFP_D_SCALAR);
            OP_VFP_DM:  return dec_vfp_bank(w, MODE_VFP_DM_SCALAR);
            OP_VFP_LSM: return dec_vfp_lsm(w);
            default:    return MODE_UNKNOWN;
        endcase
    endfunction

endpackage

// ===== design/amc_req_if.sv =====
// request channel interface: instruction class and word
// depends on amc_pkg
interface amc_req_if;
    import amc_pkg::*;

    logic  valid;
    logic  ready;
    op_t   operation;
    word_t instr_word;

    modport source (output valid, output operation, output instr_word, input ready);
    modport sink   (input valid, input operation, input instr_word, output ready);
endinterface

// ===== design/amc_rsp_if.sv =====
// response channel interface: addressing mode code
// depends on amc_pkg
interface amc_rsp_if;
    import amc_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode_code;

    modport source (output valid, output mode_code, input ready);
    modport sink   (input valid, input mode_code, output ready);
endinterface

// ===== design/arm_addressing_mode_classifier_top.sv =====
// channel  | dir | payload                       | handshake
// req      | in  | operation[3:0], instr_word[31:0] | valid/ready
// rsp      | out | mode_code[5:0]                | valid/ready
//
// one request per cycle while the result is not stalled; an accepted request passes the input
// register, then is decoded into the result register
// reset clears only the two stage valid flags
// a stalled result holds while the input register still takes one more
// request; ready drops only when both stages are full
// depends on amc_pkg, amc_req_if, amc_rsp_if
module arm_addressing_mode_classifier_top (
    input  logic      clk,
    input  logic      rst_n,
    amc_req_if.sink   req,
    amc_rsp_if.source rsp
);
    import amc_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    op_t   in_op_reg;
    word_t in_word_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    mode_t out_mode_reg;
    mode_t out_mode_next;
    logic  out_free;
    logic  in_free;

    // stage advance
    assign out_free = !out_valid_reg || rsp.ready;
    assign in_free  = !in_valid_reg || out_free;
    assign req.ready = in_free;

    assign in_valid_next  = in_free ? req.valid : in_valid_reg;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;
    assign out_mode_next  = decode_mode(in_op_reg, in_word_reg);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (req.valid && in_free)
        begin
            in_op_reg   <= req.operation;
            in_word_reg <= req.instr_word;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (in_valid_reg && out_free)
            out_mode_reg <= out_mode_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.mode_code = out_mode_reg;

endmodule

// ===== tb/sv/amc_mode_checker.sv =====
// checker for the addressing mode classifier: watches both channels,
// predicts the mode code of every accepted request and compares results in order
// depends on amc_pkg, amc_req_if, amc_rsp_if
module amc_mode_checker (
    input  logic clk,
    input  logic rst_n,
    amc_req_if   req,
    amc_rsp_if   rsp,
    output int   errors,
    output int   pending,
    output int   checked,
    output int   codes_seen
);
    import amc_pkg::*;

    mode_t       awaited_modes[$];
    logic [63:0] seen_codes;
    int          error_count;
    int          checked_count;

    // index step shared by load/store and misc load/store: offset, pre, post
    function automatic mode_t index_step(input word_t w);
        if (!w[24])
            return 6'd2;
        return w[21] ? 6'd1 : 6'd0;
    endfunction

    // expected mode code for one request
    function automatic mode_t predict_mode(input op_t op, input word_t w);
        logic [1:0] shift_kind;
        mode_t      scaled_off;
        mode_t      bank_first;
        shift_kind = w[6:5];
        scaled_off = {4'd0, shift_kind};
        bank_first = MODE_UNKNOWN;
        case (op)
            OP_DP:
            begin
                if (w[27:26] != 2'b00)
                    return MODE_UNKNOWN;
                if (w[25])
                    return MODE_DATA_IMM;
                if (w[11:4] == RRX_FIELD)
                    return MODE_DATA_RRX;
                if (!w[4])
                    return (w[11:5] == 7'd0) ? MODE_DATA_REG : MODE_DATA_IMM_LSL + scaled_off;
                return w[7] ? MODE_UNKNOWN : MODE_DATA_REG_LSL + scaled_off;
            end
            OP_LS:
            begin
                // post-indexed with writeback is the user-mode form, not classified
                if (w[27:26] != 2'b01 || (!w[24] && w[21]))
                    return MODE_UNKNOWN;
                if (!w[25])
                    return MODE_LS_IMM + index_step(w);
                if (w[11:4] == 8'd0)
                    return MODE_LS_REG + index_step(w);
                if (w[4])
                    return MODE_UNKNOWN;
                // rotate by nothing means rrx
                if (shift_kind == SH_ROR && w[11:7] == 5'd0)
                    scaled_off = 6'd4;
                return MODE_LS_SCALED_LSL + 6'd5 * index_step(w) + scaled_off;
            end
            OP_LSMISC:
            begin
                if (w[27:25] != 3'b000 || !w[7] || !w[4] || (!w[24] && w[21]))
                    return MODE_UNKNOWN;
                if (w[22])
                    return MODE_MISC_IMM + index_step(w);
                return MODE_MISC_REG + index_step(w);
            end
            OP_LSM:
            begin
                if (w[27:25] != 3'b100)
                    return MODE_UNKNOWN;
                if (w[23])
                    return w[24] ? MODE_LSM_IB : MODE_LSM_IA;
                return w[24] ? MODE_LSM_DB : MODE_LSM_DA;
            end
            OP_COPROC:
            begin
                if (w[27:25] != 3'b110)
                    return MODE_UNKNOWN;
                if (w[24])
                    return w[21] ? MODE_CP_IMM_PRE : MODE_CP_IMM;
                return w[21] ? MODE_CP_IMM_POST : MODE_CP_UNINDEXED;
            end
            OP_VFP_S, OP_VFP_SM, OP_VFP_D, OP_VFP_DM:
            begin
                case (op)
                    OP_VFP_S:  bank_first = MODE_VFP_S_SCALAR;
                    OP_VFP_SM: bank_first = MODE_VFP_SM_SCALAR;
                    OP_VFP_D:  bank_first = MODE_VFP_D_SCALAR;
                    default:   bank_first = MODE_VFP_DM_SCALAR;
                endcase
                // destination in bank zero is scalar, else source bank decides
                if (w[15:14] == 2'b00)
                    return bank_first;
                return (w[3:2] == 2'b00) ? bank_first + 6'd1 : bank_first + 6'd2;
            end
            OP_VFP_LSM:
            begin
                if (w[27:23] == VLSM_INC_TOP)
                    return w[21] ? MODE_VLSM_INC : MODE_VLSM_UNINDEXED;
                if (w[27:23] == VLSM_DEC_TOP && w[21])
                    return MODE_VLSM_DEC;
                return MODE_UNKNOWN;
            end
            default:
                return MODE_UNKNOWN;
        endcase
    endfunction

    initial
    begin
        seen_codes    = '0;
        error_count   = 0;
        checked_count = 0;
        errors        = 0;
        pending       = 0;
        checked       = 0;
        codes_seen    = 0;
    end

    // results are compared before the request of the same edge is queued
    always @(posedge clk)
    begin : watch
        mode_t want;
        if (rst_n)
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (awaited_modes.size() == 0)
                begin
                    error_count++;
                    $error("mode_code: result with no request outstanding, expected none, actual %0d",
                           rsp.mode_code);
                end
                else
                begin
                    want = awaited_modes.pop_front();
                    checked_count++;
                    seen_codes[want] = 1'b1;
                    if (rsp.mode_code !== want)
                    begin
                        error_count++;
                        $error("mode_code: expected %0d, actual %0d", want, rsp.mode_code);
                    end
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                awaited_modes.push_back(predict_mode(req.operation, req.instr_word));
        end
        errors     <= error_count;
        pending    <= awaited_modes.size();
        checked    <= checked_count;
        codes_seen <= $countones(seen_codes);
    end

endmodule

// ===== tb/sv/arm_addressing_mode_classifier_top_test.sv =====
// testbench top for the addressing mode classifier: clock, reset, request
// stimulus and result back-pressure; the checker gives the failure count
// depends on amc_pkg, amc_req_if, amc_rsp_if, amc_mode_checker and the block
module arm_addressing_mode_classifier_top_test;
    import amc_pkg::*;

    localparam op_t OP_SPARE_FIRST  = 4'd10;
    localparam op_t OP_SPARE_LAST   = 4'd15;
    localparam int  RANDOM_REQUESTS = 1400;
    localparam int  DRAIN_CYCLES    = 8;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   checked;
    int   codes_seen;
    int   sent;
    bit   steady;

    amc_req_if req();
    amc_rsp_if rsp();

    arm_addressing_mode_classifier_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    amc_mode_checker mode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .codes_seen (codes_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random word, usually with the fixed bits of its class in place
    function automatic word_t shaped_word(input op_t op);
        word_t w;
        w = $urandom;
        if ($urandom_range(0, 9) < 2)
            return w;
        case (op)
            OP_DP:
            begin
                w[27:26] = 2'b00;
                case ($urandom_range(0, 3))
                    0:       w[11:4] = RRX_FIELD;
                    1:       w[11:5] = 7'd0;
                    2:       w[7] = 1'b0;
                    default: ;
                endcase
            end
            OP_LS:
            begin
                w[27:26] = 2'b01;
                if ($urandom_range(0, 3) != 0)
                    w[4] = 1'b0;
                case ($urandom_range(0, 3))
                    0:       w[11:4] = 8'd0;
                    1:
                    begin
                        w[11:7] = 5'd0;
                        w[6:5]  = SH_ROR;
                    end
                    default: ;
                endcase
            end
            OP_LSM:
                w[27:25] = 3'b100;
            OP_LSMISC:
            begin
                w[27:25] = 3'b000;
                w[7]     = 1'b1;
                w[4]     = 1'b1;
            end
            OP_COPROC:
                w[27:25] = 3'b110;
            OP_VFP_LSM:
                w[27:23] = $urandom_range(0, 1) ? VLSM_INC_TOP : VLSM_DEC_TOP;
            default: ;
        endcase
        return w;
    endfunction

    // one request, held until accepted, then an optional gap
    task automatic send_req(input op_t op, input word_t w);
        int gap;
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.instr_word <= w;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        sent++;
        gap = steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // result back-pressure
    initial
    begin
        int run;
        int gap;
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            rsp.ready <= 1'b1;
            if (steady)
                @(posedge clk);
            else
            begin
                run = $urandom_range(1, 8);
                repeat (run) @(posedge clk);
                gap = idle_gap();
                if (gap > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        op_t op;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.operation  = OP_DP;
        req.instr_word = '0;
        sent           = 0;
        steady         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: spare classes, every decoder and its corner cases
        send_req(OP_SPARE_LAST,  32'hFFFF_FFFF);
        send_req(OP_SPARE_FIRST, 32'h0000_0000);
        send_req(OP_DP,      32'h0200_0000);
        send_req(OP_DP,      32'h0000_0060);
        send_req(OP_DP,      32'h0000_0000);
        send_req(OP_DP,      32'h0000_0F60);
        send_req(OP_DP,      32'h0000_0050);
        send_req(OP_DP,      32'h0000_0090);
        send_req(OP_DP,      32'hFFFF_FFFF);
        send_req(OP_LS,      32'h0420_0000);
        send_req(OP_LS,      32'h0520_0000);
        send_req(OP_LS,      32'h0600_0000);
        send_req(OP_LS,      32'h0720_0060);
        send_req(OP_LS,      32'h0700_0010);
        send_req(OP_LSMISC,  32'h0020_00B0);
        send_req(OP_LSMISC,  32'h0160_00B0);
        send_req(OP_LSMISC,  32'h0000_00B0);
        send_req(OP_LSM,     32'h0900_0000);
        send_req(OP_LSM,     32'h0880_0000);
        send_req(OP_COPROC,  32'h0C80_0000);
        send_req(OP_COPROC,  32'h0D20_0000);
        send_req(OP_VFP_S,   32'h0000_000C);
        send_req(OP_VFP_SM,  32'h0000_8004);
        send_req(OP_VFP_D,   32'h0000_4000);
        send_req(OP_VFP_DM,  32'h0000_C00C);
        send_req(OP_VFP_LSM, 32'h0C80_0000);
        send_req(OP_VFP_LSM, 32'h0CA0_0000);
        send_req(OP_VFP_LSM, 32'h0D00_0000);
        send_req(OP_VFP_LSM, 32'h0D20_0000);

        // random requests, with a stretch of no idling every so often
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            steady = ((n / 175) % 4 == 3);
            if (n == RANDOM_REQUESTS / 2)
                drain_results();
            if ($urandom_range(0, 19) < 18)
                op = op_t'($urandom_range(OP_DP, OP_VFP_LSM));
            else
                op = op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            send_req(op, shaped_word(op));
        end
        steady = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests sent, %0d mode codes checked, %0d of 62 codes produced",
                 sent, checked, codes_seen);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
